[src/msb_first_bit_reader_defines.svh]
// Assertion macros used by the bit reader's checker file.
`ifndef MSB_FIRST_BIT_READER_DEFINES_SVH
`define MSB_FIRST_BIT_READER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MSBR_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("msbr: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define MSBR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("msbr: next-cycle check failed");

`endif

[src/msbr_pkg.sv]
// Package of types and constants shared by the bit reader modules.
`default_nettype none

package msbr_pkg;

	localparam logic [2:0] OP_WRITE   = 3'd0;
	localparam logic [2:0] OP_RESTART = 3'd1;
	localparam logic [2:0] OP_GET     = 3'd2;
	localparam logic [2:0] OP_SKIP    = 3'd3;
	localparam logic [2:0] OP_ALIGN   = 3'd4;

	// Byte position saturates here on a long skip.
	localparam logic [12:0] POS_MAX = 13'h1FFF;

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	// Word index of the buffer length register.
	localparam logic [PADDR_W-3:0] REG_BUFFER_BYTES = '0;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [11:0] write_address;
		logic [7:0]  write_data;
		logic [14:0] bit_count;
	} cmd_t;

	typedef struct packed {
		logic [31:0] value;
		logic        underrun;
		logic [31:0] bit_offset;
	} rsp_t;

	typedef struct packed {
		logic wr;
		logic rd;
	} mem_ctl_t;

endpackage

`default_nettype wire

[src/msbr_byte_ram.sv]
// Single-port byte memory with a registered read port.
`default_nettype none

module msbr_byte_ram #(
	parameter int DEPTH = 4096,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  wire logic               clk,
	input  wire msbr_pkg::mem_ctl_t ctl,
	input  wire logic [ADDR_W-1:0]  addr,
	input  wire logic [7:0]         wdata,
	output logic [7:0]              rdata
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			mem[addr] <= wdata;
		end
		if (ctl.rd) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

[src/msbr_apb_regs.sv]
// APB register block holding the buffer length and the derived read limit.
`default_nettype none

module msbr_apb_regs #(
	parameter int STORE_BYTES = 4096
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [msbr_pkg::PADDR_W-1:0] paddr,
	input  wire logic [msbr_pkg::PDATA_W-1:0] pwdata,
	output logic [msbr_pkg::PDATA_W-1:0]      prdata,
	output logic                              pready,
	output logic [12:0]                       read_limit
);

	logic [12:0] buffer_bytes_q;
	logic        hit;

	assign pready = 1'b1;
	assign hit    = (paddr[msbr_pkg::PADDR_W-1:2] == msbr_pkg::REG_BUFFER_BYTES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buffer_bytes_q <= '0;
		end else if (psel && penable && pwrite && pready && hit) begin
			buffer_bytes_q <= pwdata[12:0];
		end
	end

	always_comb begin
		prdata = hit ? msbr_pkg::PDATA_W'(buffer_bytes_q) : '0;
	end

	// Only the first min(buffer length, store depth) bytes are readable.
	always_comb begin
		if (32'(buffer_bytes_q) > STORE_BYTES) begin
			read_limit = 13'(STORE_BYTES);
		end else begin
			read_limit = buffer_bytes_q;
		end
	end

endmodule

`default_nettype wire

[src/msbr_engine.sv]
// Read-modify sequencer: walks the byte memory, applies skips and builds results.
`default_nettype none

module msbr_engine #(
	parameter int STORE_BYTES = 4096,
	parameter int RESULT_BITS = 32,
	localparam int ADDR_W = $clog2(STORE_BYTES)
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cmd_valid,
	output logic                    cmd_ready,
	input  wire msbr_pkg::cmd_t     cmd,
	output logic                    rsp_valid,
	input  wire logic               rsp_ready,
	output msbr_pkg::rsp_t          rsp,
	input  wire logic [12:0]        read_limit,
	output msbr_pkg::mem_ctl_t      mem_ctl,
	output logic [ADDR_W-1:0]       mem_addr,
	output logic [7:0]              mem_wdata,
	input  wire logic [7:0]         mem_rdata
);

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_SKIP     = 3'd1;
	localparam logic [2:0] ST_SKIP_RD  = 3'd2;
	localparam logic [2:0] ST_SKIP_DAT = 3'd3;
	localparam logic [2:0] ST_TAKE     = 3'd4;
	localparam logic [2:0] ST_BYTE     = 3'd5;
	localparam logic [2:0] ST_HOLD     = 3'd6;

	logic [2:0]             state_q, state_d;
	logic [12:0]            pos_q, pos_d;
	logic [3:0]             bits_left_q, bits_left_d;
	logic [7:0]             cur_q, cur_d;
	logic [31:0]            pend_q, pend_d;
	logic [31:0]            req_q, req_d;
	logic                   exh_q, exh_d;
	logic [2:0]             rem_q, rem_d;
	logic [14:0]            n_q, n_d;
	logic [RESULT_BITS-1:0] acc_q, acc_d;

	logic                   rsp_valid_q;
	msbr_pkg::rsp_t         rsp_q, hold_q, fin_rsp;

	logic                   fin;
	logic [RESULT_BITS-1:0] fin_value;
	logic                   slot_free;
	logic                   in_store;
	logic [2:0]             pad;
	logic [31:0]            skip_rem;
	logic [13:0]            pos_sum;
	logic [12:0]            pos_sat;
	logic [3:0]             take;
	logic                   issue_chk;
	logic [14:0]            n_t;
	logic [RESULT_BITS-1:0] acc_t;

	assign cmd_ready = (state_q == ST_IDLE);
	assign slot_free = !rsp_valid_q || rsp_ready;
	assign in_store  = (32'(cmd.write_address) < STORE_BYTES);
	assign pad       = 3'(3'd0 - req_q[2:0]);

	// Byte position after jumping the whole bytes of a skip, saturating.
	always_comb begin
		skip_rem = pend_q - 32'(bits_left_q);
		pos_sum  = 14'(pos_q) + 14'(skip_rem[15:3]);
		if (skip_rem[31:16] != 16'd0 || pos_sum[13]) begin
			pos_sat = msbr_pkg::POS_MAX;
		end else begin
			pos_sat = pos_sum[12:0];
		end
	end

	always_comb begin
		state_d     = state_q;
		pos_d       = pos_q;
		bits_left_d = bits_left_q;
		cur_d       = cur_q;
		pend_d      = pend_q;
		req_d       = req_q;
		exh_d       = exh_q;
		rem_d       = rem_q;
		n_d         = n_q;
		acc_d       = acc_q;
		fin         = 1'b0;
		fin_value   = '0;
		mem_ctl     = '0;
		mem_addr    = ADDR_W'(pos_q);
		mem_wdata   = cmd.write_data;
		take        = '0;
		issue_chk   = 1'b0;
		n_t         = n_q;
		acc_t       = acc_q;

		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					unique case (cmd.opcode)
						msbr_pkg::OP_WRITE: begin
							mem_ctl.wr = in_store;
							mem_addr   = ADDR_W'(cmd.write_address);
							fin        = 1'b1;
						end
						msbr_pkg::OP_RESTART: begin
							pos_d       = '0;
							bits_left_d = '0;
							cur_d       = '0;
							pend_d      = '0;
							req_d       = '0;
							exh_d       = 1'b0;
							fin         = 1'b1;
						end
						msbr_pkg::OP_GET: begin
							req_d = req_q + 32'(cmd.bit_count);
							if (exh_q) begin
								fin = 1'b1;
							end else begin
								n_d     = cmd.bit_count;
								acc_d   = '0;
								state_d = (pend_q == 32'd0) ? ST_TAKE : ST_SKIP;
							end
						end
						msbr_pkg::OP_SKIP: begin
							pend_d = pend_q + 32'(cmd.bit_count);
							req_d  = req_q + 32'(cmd.bit_count);
							fin    = 1'b1;
						end
						msbr_pkg::OP_ALIGN: begin
							pend_d = pend_q + 32'(pad);
							req_d  = req_q + 32'(pad);
							fin    = 1'b1;
						end
						default: begin
							fin = 1'b1;
						end
					endcase
				end
			end
			ST_SKIP: begin
				pend_d = '0;
				if (32'(bits_left_q) >= pend_q) begin
					cur_d       = cur_q << pend_q[3:0];
					bits_left_d = bits_left_q - pend_q[3:0];
					state_d     = ST_TAKE;
				end else begin
					bits_left_d = '0;
					cur_d       = '0;
					pos_d       = pos_sat;
					rem_d       = skip_rem[2:0];
					state_d     = (skip_rem[2:0] != 3'd0) ? ST_SKIP_RD : ST_TAKE;
				end
			end
			ST_SKIP_RD: begin
				if (pos_q >= read_limit) begin
					exh_d = 1'b1;
					fin   = 1'b1;
				end else begin
					mem_ctl.rd = 1'b1;
					pos_d      = pos_q + 13'd1;
					state_d    = ST_SKIP_DAT;
				end
			end
			ST_SKIP_DAT: begin
				cur_d       = mem_rdata << rem_q;
				bits_left_d = 4'd8 - 4'(rem_q);
				state_d     = ST_TAKE;
			end
			ST_TAKE: begin
				// Drain what is left of the current byte first.
				if (bits_left_q != 4'd0 && n_q != 15'd0) begin
					take        = (n_q < 15'(bits_left_q)) ? n_q[3:0] : bits_left_q;
					acc_t       = (acc_q << take) | RESULT_BITS'(cur_q >> (4'd8 - take));
					cur_d       = cur_q << take;
					bits_left_d = bits_left_q - take;
					n_t         = n_q - 15'(take);
				end
				issue_chk = 1'b1;
			end
			ST_BYTE: begin
				if (n_q >= 15'd8) begin
					acc_t = (acc_q << 8) | RESULT_BITS'(mem_rdata);
					n_t   = n_q - 15'd8;
				end else begin
					acc_t       = (acc_q << n_q[2:0])
						| RESULT_BITS'(mem_rdata >> (4'd8 - 4'(n_q[2:0])));
					cur_d       = mem_rdata << n_q[2:0];
					bits_left_d = 4'd8 - 4'(n_q[2:0]);
					n_t         = '0;
				end
				issue_chk = 1'b1;
			end
			ST_HOLD: begin
				if (rsp_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		// Either the get is complete, or the next byte is fetched, or the buffer has run out.
		if (issue_chk) begin
			acc_d = acc_t;
			n_d   = n_t;
			if (n_t == 15'd0) begin
				fin       = 1'b1;
				fin_value = acc_t;
			end else if (pos_q >= read_limit) begin
				exh_d = 1'b1;
				fin   = 1'b1;
			end else begin
				mem_ctl.rd = 1'b1;
				pos_d      = pos_q + 13'd1;
				state_d    = ST_BYTE;
			end
		end

		fin_rsp.value      = 32'(fin_value);
		fin_rsp.underrun   = exh_d;
		fin_rsp.bit_offset = req_d;
		if (fin) begin
			state_d = slot_free ? ST_IDLE : ST_HOLD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pos_q       <= '0;
			bits_left_q <= '0;
			cur_q       <= '0;
			pend_q      <= '0;
			req_q       <= '0;
			exh_q       <= 1'b0;
			rem_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			pos_q       <= pos_d;
			bits_left_q <= bits_left_d;
			cur_q       <= cur_d;
			pend_q      <= pend_d;
			req_q       <= req_d;
			exh_q       <= exh_d;
			rem_q       <= rem_d;
			if (fin && slot_free) begin
				rsp_valid_q <= 1'b1;
			end else if (state_q == ST_HOLD) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// A result that finds the output register still full waits in the hold register.
	always_ff @(posedge clk) begin
		n_q   <= n_d;
		acc_q <= acc_d;
		if (fin && slot_free) begin
			rsp_q <= fin_rsp;
		end else if (state_q == ST_HOLD && rsp_ready) begin
			rsp_q <= hold_q;
		end
		if (fin && !slot_free) begin
			hold_q <= fin_rsp;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

[src/msb_first_bit_reader.sv]
// Top level of the MSB-first bit stream reader.
// Usage:
// Items enter on the cmd channel (valid/ready) and each gives exactly one item
// on the rsp channel (valid/ready), in order. Write-byte items fill the byte
// memory; get, skip, align and restart items move the read position.
// The buffer length register sits at APB word 0; pready is always high.
// Write, restart, skip, align and gets after an underrun take one cycle.
// A get drains the current byte in the take state, then fetches each new byte in
// turn from the single-port byte memory; a pending skip adds a skip state, and a
// skip that lands inside a byte also reads that byte before the get goes on.
// cmd_ready is high only while the sequencer is idle. A finished result sits
// in the output register; the next item is taken meanwhile, and its result
// waits in a hold register until the receiver takes the first one.
// Reset clears the read position, the skip and offset counters, the underrun
// flag and the buffer length. Memory contents are undefined until written.
`default_nettype none

module msb_first_bit_reader #(
	parameter int STORE_BYTES = 4096,
	parameter int RESULT_BITS = 32
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [msbr_pkg::PADDR_W-1:0] paddr,
	input  wire logic [msbr_pkg::PDATA_W-1:0] pwdata,
	output logic [msbr_pkg::PDATA_W-1:0]      prdata,
	output logic                              pready,
	input  wire logic                         cmd_valid,
	output logic                              cmd_ready,
	input  wire msbr_pkg::cmd_t               cmd,
	output logic                              rsp_valid,
	input  wire logic                         rsp_ready,
	output msbr_pkg::rsp_t                    rsp
);

	localparam int ADDR_W = $clog2(STORE_BYTES);

	logic [12:0]        read_limit;
	msbr_pkg::mem_ctl_t mem_ctl;
	logic [ADDR_W-1:0]  mem_addr;
	logic [7:0]         mem_wdata;
	logic [7:0]         mem_rdata;

	msbr_apb_regs #(
		.STORE_BYTES(STORE_BYTES)
	) u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.read_limit(read_limit)
	);

	msbr_byte_ram #(
		.DEPTH(STORE_BYTES)
	) u_ram (
		.clk  (clk),
		.ctl  (mem_ctl),
		.addr (mem_addr),
		.wdata(mem_wdata),
		.rdata(mem_rdata)
	);

	msbr_engine #(
		.STORE_BYTES(STORE_BYTES),
		.RESULT_BITS(RESULT_BITS)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.read_limit(read_limit),
		.mem_ctl   (mem_ctl),
		.mem_addr  (mem_addr),
		.mem_wdata (mem_wdata),
		.mem_rdata (mem_rdata)
	);

endmodule

`default_nettype wire

[src/msbr_checker.sv]
// Port-level checker for the bit reader, bound to the top level.
`default_nettype none
`include "msb_first_bit_reader_defines.svh"

module msbr_checker #(
	parameter int RESULT_BITS = 32
) (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           rsp_valid,
	input wire logic           rsp_ready,
	input wire msbr_pkg::rsp_t rsp
);

	// A stalled result item holds.
	`MSBR_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

	// Once the buffer has run out, every result carries a zero value.
	`MSBR_ASSERT_NOW(a_underrun_zero, clk, arst_n, rsp_valid && rsp.underrun, rsp.value == 32'd0)

	// A get keeps only the configured number of result bits.
	`MSBR_ASSERT_NOW(a_value_width, clk, arst_n, rsp_valid, (rsp.value >> RESULT_BITS) == 32'd0)

endmodule

bind msb_first_bit_reader msbr_checker #(
	.RESULT_BITS(RESULT_BITS)
) u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.rsp_valid(rsp_valid),
	.rsp_ready(rsp_ready),
	.rsp      (rsp)
);

`default_nettype wire
